// ===== sv/bbc_pkg.sv =====
package bbc_pkg;

   // Bracket kind codes kept on the stack
   typedef logic [1:0] kind_type;

   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_PAREN = 2'd1;
   localparam kind_type KIND_SQUARE = 2'd2;
   localparam kind_type KIND_CURLY = 2'd3;

   // Result status codes; the error latch uses the same encoding
   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_CLOSER   = 2'd1;
   localparam status_type STATUS_UNCLOSED = 2'd2;
   localparam status_type STATUS_OVERFLOW = 2'd3;

   localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
   localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
   localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic       balanced;
      status_type status;
   } rsp_type;

   function automatic kind_type opener_kind(input logic [7:0] c);
      kind_type k;
      k = KIND_NONE;
      case (c)
         CHAR_OPEN_PAREN:  k = KIND_PAREN;
         CHAR_OPEN_SQUARE: k = KIND_SQUARE;
         CHAR_OPEN_CURLY:  k = KIND_CURLY;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic kind_type closer_kind(input logic [7:0] c);
      kind_type k;
      k = KIND_NONE;
      case (c)
         CHAR_CLOSE_PAREN:  k = KIND_PAREN;
         CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
         CHAR_CLOSE_CURLY:  k = KIND_CURLY;
         default:           k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/bbc_stack_ram.sv =====
module bbc_stack_ram
   import bbc_pkg::*;
#(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  kind_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output kind_type      rd_data
);

   kind_type stack_mem_ff [DEPTH];
   kind_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; returns old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= stack_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bbc_engine.sv =====
module bbc_engine
   import bbc_pkg::*;
#(
   parameter int unsigned DEPTH = 32,
   parameter int unsigned AW    = $clog2(DEPTH),
   parameter int unsigned DW    = $clog2(DEPTH + 1)
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output rsp_type result
);

   localparam logic [DW-1:0] DEPTH_FULL = DW'(DEPTH);

   logic [DW-1:0] depth_ff, depth_in;
   status_type    error_ff, error_in;
   logic          fwd_hit_ff, fwd_hit_in;
   kind_type      fwd_data_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   kind_type      wr_data;
   logic [AW-1:0] rd_addr;
   kind_type      rd_data;
   kind_type      top_kind;
   kind_type      open_k;
   kind_type      close_k;
   logic [DW-1:0] depth_after;
   status_type    error_after;
   logic [DW-1:0] rd_ptr;

   bbc_stack_ram #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Top entry: take the last write when it hit the address just read
   assign top_kind = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign open_k   = opener_kind(req.char_code);
   assign close_k  = closer_kind(req.char_code);

   always_comb begin
      depth_after = depth_ff;
      error_after = error_ff;
      wr_en       = 1'b0;
      wr_addr     = depth_ff[AW-1:0];
      wr_data     = open_k;
      if (accept && (error_ff == STATUS_OK)) begin
         if (open_k != KIND_NONE) begin
            if (depth_ff == DEPTH_FULL) begin
               error_after = STATUS_OVERFLOW;
            end else begin
               wr_en       = 1'b1;
               depth_after = depth_ff + DW'(1);
            end
         end else if (close_k != KIND_NONE) begin
            if ((depth_ff == '0) || (top_kind != close_k)) begin
               error_after = STATUS_CLOSER;
            end else begin
               depth_after = depth_ff - DW'(1);
            end
         end
      end

      result.status = error_after;
      if ((error_after == STATUS_OK) && (depth_after != '0)) begin
         result.status = STATUS_UNCLOSED;
      end
      result.balanced = (result.status == STATUS_OK);

      depth_in = depth_after;
      error_in = error_after;
      if (accept && req.last_char) begin
         depth_in = '0;
         error_in = STATUS_OK;
      end

      // Fetch the entry that will be on top next cycle
      rd_ptr     = depth_in - DW'(1);
      rd_addr    = rd_ptr[AW-1:0];
      fwd_hit_in = wr_en && (wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         error_ff   <= STATUS_OK;
         fwd_hit_ff <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         error_ff   <= error_in;
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

endmodule

// ===== sv/bracket_balance_checker_top.sv =====
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | req_data (char_code, last_char)
// rsp     | out       | rsp_valid / rsp_stall  | rsp_data (balanced, status)
//
// One character per cycle, back to back, unless req_stall holds the input; the
// verdict is loaded into the output register as the character marked last_char is taken.
// The stack lives in a one-port-write, one-port-read memory with a
// registered read; a forwarding register covers a read of the entry just pushed.
// Synchronous active-high reset clears depth, error latch and output valid;
// stack contents are left as they are and never read before written.
// req_stall rises only while a finished verdict waits on a stalled rsp side.
module bracket_balance_checker_top
   import bbc_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    accept;
   rsp_type result;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // Hold the input only when the output register is full and blocked
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   bbc_engine #(
      .DEPTH(STACK_DEPTH)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .result(result)
   );

   // Load a verdict on the last character; drop valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept && req_data.last_char) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.last_char) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/bbc_checker.sv =====
module bbc_checker
   import bbc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled verdict stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!reset && rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled rsp item changed or dropped");

   a_balanced_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.balanced == (rsp_data.status == STATUS_OK)))
      else $error("balanced flag disagrees with status");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && !req_stall && req_data.last_char) |=> rsp_valid)
      else $error("last character gave no verdict");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      (!reset && !(req_valid && !req_stall && req_data.last_char))
         |=> (rsp_valid == $past(rsp_valid && rsp_stall)))
      else $error("verdict appeared without a last character");

endmodule

bind bracket_balance_checker_top bbc_checker u_bbc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// ===== dv/testbench.sv =====
module testbench;
   import bbc_pkg::*;

   localparam int unsigned STACK_LIMIT  = 32;
   localparam int unsigned RANDOM_ITEMS = 1850;
   localparam int unsigned IDLE_PCT     = 27;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Random idling on both sides; cleared for a long quiet stretch
   bit          idle_enable = 1'b1;
   // Input items sent so far
   int unsigned counted     = 0;
   // Characters of the string being built
   logic [7:0]  text_q[$];

   // Track the bracket nesting of the current string and queue the verdict
   // that each string end should produce.
   class bracket_scoreboard;
      kind_type    open_kinds[STACK_LIMIT];
      int unsigned open_count  = 0;
      status_type  first_error = STATUS_OK;
      rsp_type     verdict_q[$];
      int unsigned fail_count  = 0;

      function void note_char(req_type item);
         kind_type   k;
         bit         opens;
         status_type status;
         rsp_type    verdict;
         k     = KIND_NONE;
         opens = 1'b0;
         case (item.char_code)
            CHAR_OPEN_PAREN:   begin k = KIND_PAREN;  opens = 1'b1; end
            CHAR_OPEN_SQUARE:  begin k = KIND_SQUARE; opens = 1'b1; end
            CHAR_OPEN_CURLY:   begin k = KIND_CURLY;  opens = 1'b1; end
            CHAR_CLOSE_PAREN:  k = KIND_PAREN;
            CHAR_CLOSE_SQUARE: k = KIND_SQUARE;
            CHAR_CLOSE_CURLY:  k = KIND_CURLY;
            default:           k = KIND_NONE;
         endcase
         // Once an error is latched, the rest of the string is dead
         if (first_error == STATUS_OK && k != KIND_NONE) begin
            if (opens) begin
               if (open_count >= STACK_LIMIT) begin
                  first_error = STATUS_OVERFLOW;
               end else begin
                  open_kinds[open_count] = k;
                  open_count++;
               end
            end else if (open_count == 0 || open_kinds[open_count - 1] != k) begin
               first_error = STATUS_CLOSER;
            end else begin
               open_count--;
            end
         end
         if (item.last_char) begin
            if (first_error != STATUS_OK) status = first_error;
            else if (open_count != 0) status = STATUS_UNCLOSED;
            else status = STATUS_OK;
            verdict.balanced = (status == STATUS_OK);
            verdict.status   = status;
            verdict_q.push_back(verdict);
            open_count  = 0;
            first_error = STATUS_OK;
         end
      endfunction

      function void check_verdict(rsp_type got);
         rsp_type want;
         if (verdict_q.size() == 0) begin
            $display("%0t: unexpected verdict, expected none, actual balanced=%0b status=%0d",
                     $time, got.balanced, got.status);
            fail_count++;
            return;
         end
         want = verdict_q.pop_front();
         if (got.balanced !== want.balanced) begin
            $display("%0t: balanced mismatch, expected %0b, actual %0b",
                     $time, want.balanced, got.balanced);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            fail_count++;
         end
      endfunction

      function int unsigned pending();
         return verdict_q.size();
      endfunction
   endclass

   bracket_scoreboard board = new;

   bracket_balance_checker_top #(
      .STACK_DEPTH(STACK_LIMIT)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // 10-unit clock period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: stall at random, changed only on the falling edge
   always @(negedge clock) begin
      rsp_stall <= idle_enable && ($urandom_range(99) < IDLE_PCT);
   end

   // Check every verdict taken by the receiver
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_verdict(rsp_data);
      end
   end

   function automatic logic [7:0] opener_char(kind_type k);
      case (k)
         KIND_PAREN:  return CHAR_OPEN_PAREN;
         KIND_SQUARE: return CHAR_OPEN_SQUARE;
         default:     return CHAR_OPEN_CURLY;
      endcase
   endfunction

   function automatic logic [7:0] closer_char(kind_type k);
      case (k)
         KIND_PAREN:  return CHAR_CLOSE_PAREN;
         KIND_SQUARE: return CHAR_CLOSE_SQUARE;
         default:     return CHAR_CLOSE_CURLY;
      endcase
   endfunction

   function automatic bit is_bracket(logic [7:0] c);
      return c == CHAR_OPEN_PAREN  || c == CHAR_OPEN_SQUARE  || c == CHAR_OPEN_CURLY ||
             c == CHAR_CLOSE_PAREN || c == CHAR_CLOSE_SQUARE || c == CHAR_CLOSE_CURLY;
   endfunction

   function automatic bit is_closer(logic [7:0] c);
      return c == CHAR_CLOSE_PAREN || c == CHAR_CLOSE_SQUARE || c == CHAR_CLOSE_CURLY;
   endfunction

   function automatic kind_type any_kind();
      return kind_type'($urandom_range(KIND_CURLY, KIND_PAREN));
   endfunction

   // Any byte that is not a bracket
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (is_bracket(c));
      return c;
   endfunction

   // Hold one item until taken; idle first at random
   task automatic send_char(input logic [7:0] c, input bit last);
      req_type item;
      item.char_code = c;
      item.last_char = last;
      while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_char(item);
      counted++;
      @(negedge clock);
   endtask

   // Send the built string, marking its final character
   task automatic send_string();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   task automatic send_text(input string s);
      text_q.delete();
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
      send_string();
   endtask

   // Hold off the sender until every verdict has come back
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Random walk of pushes and pops with plain characters mixed in;
   // close whatever is still open at the end
   task automatic build_balanced(input int unsigned max_nest, input int unsigned steps);
      kind_type    nest[$];
      kind_type    k;
      int unsigned r;
      for (int unsigned i = 0; i < steps; i++) begin
         r = $urandom_range(9);
         if (r < 2) begin
            text_q.push_back(plain_char());
         end else if (nest.size() < max_nest && (nest.size() == 0 || r < 6)) begin
            k = any_kind();
            nest.push_back(k);
            text_q.push_back(opener_char(k));
         end else begin
            text_q.push_back(closer_char(nest.pop_back()));
         end
      end
      while (nest.size() != 0) text_q.push_back(closer_char(nest.pop_back()));
   endtask

   // Fill the stack exactly to the top, then unwind it
   task automatic build_full();
      kind_type nest[$];
      kind_type k;
      for (int unsigned i = 0; i < STACK_LIMIT; i++) begin
         k = any_kind();
         nest.push_back(k);
         text_q.push_back(opener_char(k));
         if ($urandom_range(9) == 0) text_q.push_back(plain_char());
      end
      while (nest.size() != 0) text_q.push_back(closer_char(nest.pop_back()));
   endtask

   // Swap one closer for a closer of another kind, or prepend a closer if there is none
   task automatic break_closer();
      int unsigned spots[$];
      int unsigned idx;
      kind_type    k;
      foreach (text_q[i]) if (is_closer(text_q[i])) spots.push_back(i);
      if (spots.size() == 0) begin
         text_q.push_front(closer_char(any_kind()));
         return;
      end
      idx = spots[$urandom_range(spots.size() - 1)];
      do k = any_kind(); while (closer_char(k) == text_q[idx]);
      text_q[idx] = closer_char(k);
   endtask

   initial begin
      bit          drained;
      int unsigned mode;
      drained = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: each bracket kind, nesting, closer on empty stack,
      // mismatched closer, unclosed openers, error ahead of open entries,
      // and the extreme byte values as lone plain characters
      send_text("()");
      send_text("[]");
      send_text("{}");
      send_text("([{}])");
      send_text(")");
      send_text("(]");
      send_text("((");
      send_text("]a(");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      wait_for_verdicts();

      // Random strings, half of them well formed, the rest broken or plain noise
      while (counted < RANDOM_ITEMS) begin
         idle_enable = !(counted >= 600 && counted < 1000);
         if (!drained && counted >= 1200) begin
            wait_for_verdicts();
            drained = 1'b1;
         end
         text_q.delete();
         mode = $urandom_range(99);
         if (mode < 44) begin
            build_balanced($urandom_range(6, 1), $urandom_range(12, 1));
         end else if (mode < 50) begin
            build_full();
         end else if (mode < 60) begin
            build_balanced($urandom_range(6, 1), $urandom_range(12, 1));
            break_closer();
         end else if (mode < 67) begin
            // Closer on an empty stack somewhere in the string
            build_balanced($urandom_range(4, 1), $urandom_range(8, 1));
            text_q.push_back(closer_char(any_kind()));
            build_balanced($urandom_range(4, 1), $urandom_range(6, 0));
         end else if (mode < 77) begin
            build_balanced($urandom_range(4, 1), $urandom_range(8, 1));
            repeat ($urandom_range(3, 1)) text_q.push_back(opener_char(any_kind()));
            repeat ($urandom_range(2, 0)) text_q.push_back(plain_char());
         end else if (mode < 85) begin
            // Push past the top of the stack, then trail off
            repeat (STACK_LIMIT + $urandom_range(3, 1))
               text_q.push_back(opener_char(any_kind()));
            repeat ($urandom_range(4, 0))
               text_q.push_back(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(8, 1)) text_q.push_back(8'($urandom_range(255)));
         end
         send_string();
      end
      req_valid <= 1'b0;

      // Drain, then allow the output stage to settle
      while (board.pending() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (board.pending() != 0) begin
         $display("%0t: %0d verdicts never arrived", $time, board.pending());
         board.fail_count++;
      end
      if (board.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest passing run
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/bbc_pkg.sv
sv/bbc_stack_ram.sv
sv/bbc_engine.sv
sv/bracket_balance_checker_top.sv
sv/bbc_checker.sv
dv/testbench.sv
